/* src/acfm_pkg.sv */
package acfm_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int POS_W       = 24;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;

    localparam logic [POS_W-1:0]  POS_MAX            = {POS_W{1'b1}};
    localparam logic [POS_W-1:0]  FADE_LENGTH_RESET  = 24'd96000;
    localparam logic [MODE_W-1:0] CURVE_MODE_RESET   = 2'd0;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CURVE_MODE  = 1'b1;

    // Curve codes; any other code acts as a hard cut.
    localparam logic [MODE_W-1:0] MODE_SINE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;

    typedef enum logic
    {
        OP_MIX,
        OP_RESTART
    } op_t;

    typedef struct packed
    {
        op_t                       op;
        logic signed [SAMPLE_W-1:0] outgoing_sample;
        logic signed [SAMPLE_W-1:0] incoming_sample;
        logic                      segment_end;
    } queue_entry_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_RD_IN,
        ST_RD_OUT,
        ST_MUL_OUT,
        ST_MUL_IN,
        ST_SUM,
        ST_EMIT
    } back_state_t;

endpackage

/* src/acfm_ifs.sv */
interface mix_in_if;
    import acfm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       command;
    logic signed [SAMPLE_W-1:0] outgoing_sample;
    logic signed [SAMPLE_W-1:0] incoming_sample;
    logic                       segment_end;

    modport source
    (
        output valid, command, outgoing_sample, incoming_sample, segment_end,
        input  ready
    );
    modport sink
    (
        input  valid, command, outgoing_sample, incoming_sample, segment_end,
        output ready
    );
endinterface

interface mix_out_if;
    import acfm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       fade_done;
    logic                       last;

    modport source
    (
        output valid, mixed_sample, fade_done, last,
        input  ready
    );
    modport sink
    (
        input  valid, mixed_sample, fade_done, last,
        output ready
    );
endinterface

interface cfg_wr_if;
    import acfm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source
    (
        output valid, index, data,
        input  ready
    );
    modport sink
    (
        input  valid, index, data,
        output ready
    );
endinterface

/* src/audio_crossfade_mixer_top.sv */
// Audio crossfade mixer: blends an outgoing and an incoming 32-bit sample stream.
// Channel samples takes one item per sample pair (command, outgoing_sample,
// incoming_sample, segment_end); a restart item clears the fade position and
// yields no result. Channel mixed returns one item per mix item with the
// truncated, saturated mixed_sample, fade_done and last.
// Channel cfg writes fade_length (index 0) and curve_mode (index 1); it is always
// ready and should be used only while no item is in flight.
// A mix item runs through the bit-serial fraction divider, two reads of the
// single-port sine ROM, two products on the one shared multiplier, a sum and
// the output register; the linear curve and a hard cut skip the ROM reads, and
// the divider is skipped once the position has reached the fade length. A
// restart is applied as it leaves the queue.
// A two-item queue sits in front, so while a result waits in the output register
// for a stalled receiver up to three more items are accepted (one held in the
// back end, two in the queue); results are never lost.
// Reset empties the queue and output register, clears the fade position and
// loads fade_length 96000 and curve_mode 0 (sine/cosine).
module audio_crossfade_mixer_top
    import acfm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH   = 1024,
    parameter int GAIN_FRACTION_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    mix_in_if.sink     samples,
    mix_out_if.source  mixed,
    cfg_wr_if.sink     cfg
);

    logic [POS_W-1:0]  fade_length_reg;
    logic [MODE_W-1:0] curve_mode_reg;
    queue_entry_t      q_entry;
    logic              q_valid;
    logic              q_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_length_reg <= FADE_LENGTH_RESET;
            curve_mode_reg  <= CURVE_MODE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_FADE_LENGTH: fade_length_reg <= cfg.data[POS_W-1:0];
                REG_CURVE_MODE:  curve_mode_reg  <= cfg.data[MODE_W-1:0];
                default:         fade_length_reg <= fade_length_reg;
            endcase
        end
    end

    acfm_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .q_entry (q_entry),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    acfm_back
    #(
        .SINE_TABLE_DEPTH   (SINE_TABLE_DEPTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_entry     (q_entry),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .fade_length (fade_length_reg),
        .curve_mode  (curve_mode_reg),
        .mixed       (mixed)
    );

endmodule

/* src/acfm_front.sv */
module acfm_front
    import acfm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mix_in_if.sink       samples,
    output queue_entry_t q_entry,
    output logic         q_valid,
    input  logic         q_pop
);

    queue_entry_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         push;
    logic         pop;
    queue_entry_t new_entry;

    assign samples.ready = (count_reg != 2'd2);
    assign push          = samples.valid && samples.ready;
    assign pop           = q_pop && q_valid;
    assign q_valid       = (count_reg != 2'd0);
    assign q_entry       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_entry.op              = samples.command ? OP_RESTART : OP_MIX;
        new_entry.outgoing_sample = samples.outgoing_sample;
        new_entry.incoming_sample = samples.incoming_sample;
        new_entry.segment_end     = samples.segment_end;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

/* src/acfm_back.sv */
module acfm_back
    import acfm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH   = 1024,
    parameter int GAIN_FRACTION_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_entry_t      q_entry,
    input  logic              q_valid,
    output logic              q_pop,
    input  logic [POS_W-1:0]  fade_length,
    input  logic [MODE_W-1:0] curve_mode,
    mix_out_if.source         mixed
);

    localparam int W_W    = GAIN_FRACTION_BITS + 1;
    localparam int J_W    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int JP_W   = W_W + J_W;
    localparam int CNT_W  = $clog2(GAIN_FRACTION_BITS);
    localparam int P_W    = SAMPLE_W + W_W + 1;
    localparam int S_W    = P_W + 1;

    localparam logic [W_W-1:0]        ONE_W    = W_W'(1) << GAIN_FRACTION_BITS;
    localparam logic [J_W-1:0]        DEPTH_J  = J_W'(SINE_TABLE_DEPTH);
    localparam logic [CNT_W-1:0]      CNT_LAST = CNT_W'(GAIN_FRACTION_BITS - 1);
    localparam logic signed [S_W-1:0] BIAS     = (S_W'(1) << GAIN_FRACTION_BITS) - S_W'(1);
    localparam logic [SAMPLE_W-1:0]   SAT_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0]   SAT_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Quarter-wave sine entry, round(65535 * sin(pi/2 * k / depth)), from a
    // Q30 Taylor series; evaluated only at elaboration.
    function automatic logic [15:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] prod;
        logic [63:0] v;
        x    = (64'd1686629713 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 6; n++)
        begin
            prod = (term * x2) >> 30;
            unique case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                default: term = prod / 64'd156;
            endcase
            if ((n % 2) == 1)
            begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end
            else
            begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd65535 + 64'd536870912) >> 30;
        if (v > 64'd65535)
        begin
            v = 64'd65535;
        end
        return v[15:0];
    endfunction

    function automatic logic [W_W-1:0] rom_weight(input logic [15:0] e, input logic full);
        logic [15+GAIN_FRACTION_BITS:0] ext;
        ext = {e, {GAIN_FRACTION_BITS{1'b0}}} >> 16;
        return full ? ONE_W : ext[W_W-1:0];
    endfunction

    logic [15:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_rom
        assign sine_rom[k] = sine_entry(k);
    end

    back_state_t                state_reg;
    back_state_t                state_next;
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           rem_reg;
    logic [W_W-1:0]             d_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [J_W-1:0]             j_reg;
    logic [W_W-1:0]             wl_reg;
    logic [W_W-1:0]             wr_reg;
    logic [15:0]                rom_q_reg;
    logic signed [SAMPLE_W-1:0] out_s_reg;
    logic signed [SAMPLE_W-1:0] in_s_reg;
    logic                       seg_reg;
    logic signed [P_W-1:0]      p_out_reg;
    logic signed [P_W-1:0]      p_in_reg;
    logic signed [S_W-1:0]      sum_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_done_reg;
    logic                       out_last_reg;

    logic                       start_full;
    logic [POS_W:0]             div_shift;
    logic                       div_ge;
    logic [JP_W-1:0]            j_prod;
    logic [J_W-1:0]             j_comb;
    logic [ADDR_W-1:0]          rom_addr;
    logic signed [SAMPLE_W-1:0] mul_s;
    logic [W_W-1:0]             mul_w;
    logic signed [P_W-1:0]      mul_res;
    logic                       load_out;
    logic signed [S_W-1:0]      biased;
    logic signed [S_W-1:0]      shr;
    logic                       sat;
    logic [SAMPLE_W-1:0]        result;
    logic [POS_W-1:0]           pos_inc;
    logic                       done;

    assign start_full = (pos_reg >= fade_length);
    assign div_shift  = {rem_reg, 1'b0};
    assign div_ge     = (div_shift >= {1'b0, fade_length});
    assign j_prod     = JP_W'(d_reg) * JP_W'(SINE_TABLE_DEPTH);
    assign j_comb     = J_W'(j_prod >> GAIN_FRACTION_BITS);
    assign mul_res    = mul_s * $signed({1'b0, mul_w});

    // Divide the sum by the gain scale with truncation toward zero, then saturate.
    assign biased = sum_reg + (sum_reg[S_W-1] ? BIAS : S_W'(0));
    assign shr    = biased >>> GAIN_FRACTION_BITS;
    assign sat    = !((&shr[S_W-1:SAMPLE_W-1]) || !(|shr[S_W-1:SAMPLE_W-1]));
    assign result = sat ? (shr[S_W-1] ? SAT_MIN : SAT_MAX) : shr[SAMPLE_W-1:0];

    assign pos_inc = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
    assign done    = seg_reg && (pos_inc >= fade_length);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (q_entry.op == OP_MIX))
                begin
                    state_next = start_full ? ST_ADDR : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:    state_next = (curve_mode == MODE_SINE) ? ST_RD_IN : ST_MUL_OUT;
            ST_RD_IN:   state_next = ST_RD_OUT;
            ST_RD_OUT:  state_next = ST_MUL_OUT;
            ST_MUL_OUT: state_next = ST_MUL_IN;
            ST_MUL_IN:  state_next = ST_SUM;
            ST_SUM:     state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = (state_reg == ST_IDLE) && q_valid;
        load_out = (state_reg == ST_EMIT) && (!out_valid_reg || mixed.ready);
        rom_addr = '0;
        mul_s    = out_s_reg;
        mul_w    = wr_reg;
        unique case (state_reg)
            ST_ADDR:
            begin
                rom_addr = (j_comb == DEPTH_J) ? ADDR_W'(0) : j_comb[ADDR_W-1:0];
            end
            ST_RD_IN:
            begin
                rom_addr = (j_reg == J_W'(0)) ? ADDR_W'(0) : ADDR_W'(DEPTH_J - j_reg);
            end
            ST_MUL_IN:
            begin
                mul_s = in_s_reg;
                mul_w = wl_reg;
            end
            default:
            begin
                rom_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && (q_entry.op == OP_RESTART))
            begin
                pos_reg <= '0;
            end
            else if (load_out)
            begin
                pos_reg <= done ? fade_length : pos_inc;
            end
            if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (mixed.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= sine_rom[rom_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_s_reg <= q_entry.outgoing_sample;
            in_s_reg  <= q_entry.incoming_sample;
            seg_reg   <= q_entry.segment_end;
            rem_reg   <= pos_reg;
            d_reg     <= start_full ? ONE_W : W_W'(0);
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= div_ge ? POS_W'(div_shift - {1'b0, fade_length}) : div_shift[POS_W-1:0];
            d_reg   <= {d_reg[W_W-2:0], div_ge};
        end
        if (state_reg == ST_ADDR)
        begin
            j_reg <= j_comb;
            if (curve_mode == MODE_LINEAR)
            begin
                wl_reg <= d_reg;
                wr_reg <= ONE_W - d_reg;
            end
            else if (curve_mode != MODE_SINE)
            begin
                wl_reg <= ONE_W;
                wr_reg <= '0;
            end
        end
        if (state_reg == ST_RD_IN)
        begin
            wl_reg <= rom_weight(rom_q_reg, j_reg == DEPTH_J);
        end
        if (state_reg == ST_RD_OUT)
        begin
            wr_reg <= rom_weight(rom_q_reg, j_reg == J_W'(0));
        end
        if (state_reg == ST_MUL_OUT)
        begin
            p_out_reg <= mul_res;
        end
        if (state_reg == ST_MUL_IN)
        begin
            p_in_reg <= mul_res;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= S_W'(p_out_reg) + S_W'(p_in_reg);
        end
        if (load_out)
        begin
            out_sample_reg <= result;
            out_done_reg   <= done;
            out_last_reg   <= seg_reg;
        end
    end

    assign mixed.valid        = out_valid_reg;
    assign mixed.mixed_sample = out_sample_reg;
    assign mixed.fade_done    = out_done_reg;
    assign mixed.last         = out_last_reg;

`ifndef NO_ASSERTIONS
    // The partial remainder of the fraction divider stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < fade_length))
        else $error("divider remainder not below fade length");

    // Neither weight ever exceeds unity gain when the products are formed.
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_OUT) |-> ((wl_reg <= ONE_W) && (wr_reg <= ONE_W)))
        else $error("crossfade weight above unity");

    // The linear curve splits unity gain exactly between the two streams.
    a_linear_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MUL_OUT) && (curve_mode == MODE_LINEAR))
        |-> ((W_W + 1)'(wl_reg) + (W_W + 1)'(wr_reg) == (W_W + 1)'(ONE_W)))
        else $error("linear weights do not sum to unity");

    // A finished fade leaves the position clamped at the fade length.
    a_done_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && done) |=> (pos_reg == $past(fade_length)))
        else $error("position not clamped after fade done");
`endif

endmodule
